>>> hdl/gbed_pkg.sv
// gap buffer line editor: shared types and constants
// operation codes, control states and stream widths; no dependencies
package gbed_pkg;

  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 8;
  localparam int POS_W      = 9;
  localparam int CFG_W      = 9;
  localparam int CFG_RST    = 256;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_DELETE    = 3'd2,
    OP_LEFT      = 3'd3,
    OP_RIGHT     = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } st_t;

endpackage

>>> hdl/gap_buffer_line_editor_top.sv
// gap buffer line editor: character memory with cursor and gap registers
// depends on gbed_pkg
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  op, char_in, read_index
// m_*       out  m_tvalid/m_tready  char_out, cursor_pos, text_length, status
// cfg_*     in   cfg_we             capacity_in_use
//
// each item is accepted with a memory read, then modified and written back
// a new item is taken while the previous result waits in the output register
// the write-back cycle holds while that register is still full
// rst is synchronous; the character memory has no reset and needs no clearing pass
// cursor starts at zero, gap at min(256, CAPACITY)
module gap_buffer_line_editor_top
  import gbed_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // op[2:0], char_in[10:3], read_index[18:11]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // char_out[7:0], cursor_pos[16:8],
                                         // text_length[25:17], status[26]
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW      = $clog2(CAPACITY);
  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int XW      = CW + 9;
  localparam int TOT_RST = (CAPACITY < CFG_RST) ? CAPACITY : CFG_RST;

  st_t state, state_next;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] rdata;
  logic              mem_re;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;

  logic [CFG_W-1:0]  cap_reg;
  logic [CW-1:0]     cursor, cursor_next;
  logic [CW-1:0]     gap, gap_next;
  logic [CW-1:0]     total, total_next;

  op_t               op_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;

  op_t               in_op;
  logic [CHAR_W-1:0] in_char;
  logic [IDX_W-1:0]  in_idx;
  logic              s_fire;
  logic              exec_fire;

  logic              refused;
  logic [CHAR_W-1:0] ch;
  logic              at_end;
  logic [CW-1:0]     len;
  logic [CW-1:0]     cap_clamped;
  logic [XW-1:0]     cap_x;
  logic [XW-1:0]     in_idx_x;
  logic [XW-1:0]     sum_x;
  logic [CW-1:0]     len_next;

  assign in_op   = op_t'(s_tdata[2:0]);
  assign in_char = s_tdata[10:3];
  assign in_idx  = s_tdata[18:11];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_fire) state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    exec_fire = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: exec_fire = !m_tvalid || m_tready;
      default: begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign s_fire = s_tvalid && s_tready;

  // read address at accept
  always_comb begin
    in_idx_x = XW'(in_idx);
    mem_re   = 1'b0;
    raddr    = cursor[AW-1:0];
    sum_x    = '0;
    if (s_fire) begin
      case (in_op)
        OP_LEFT: begin
          mem_re = 1'b1;
          sum_x  = XW'(cursor) - XW'(1);
          raddr  = sum_x[AW-1:0];
        end
        OP_RIGHT: begin
          mem_re = 1'b1;
          sum_x  = XW'(cursor) + XW'(gap);
          raddr  = sum_x[AW-1:0];
        end
        OP_READ: begin
          mem_re = 1'b1;
          if (in_idx_x < XW'(cursor)) begin
            sum_x = in_idx_x;
          end else begin
            sum_x = in_idx_x + XW'(gap);
          end
          raddr = sum_x[AW-1:0];
        end
        default: mem_re = 1'b0;
      endcase
    end
  end

  // modify and write back
  always_comb begin
    cap_x = XW'(cap_reg);
    if (cap_x == '0) begin
      cap_clamped = CW'(1);
    end else if (cap_x > XW'(CAPACITY)) begin
      cap_clamped = CW'(CAPACITY);
    end else begin
      cap_clamped = cap_x[CW-1:0];
    end
    at_end      = ({1'b0, cursor} + {1'b0, gap}) >= {1'b0, total};
    len         = total - gap;
    cursor_next = cursor;
    gap_next    = gap;
    total_next  = total;
    refused     = 1'b0;
    ch          = '0;
    mem_we      = 1'b0;
    waddr       = cursor[AW-1:0];
    wdata       = char_q;
    case (op_q)
      OP_INSERT: begin
        if (gap == '0) begin
          refused = 1'b1;
        end else begin
          mem_we      = exec_fire;
          cursor_next = cursor + CW'(1);
          gap_next    = gap - CW'(1);
        end
      end
      OP_BACKSPACE: begin
        if (cursor == '0) begin
          refused = 1'b1;
        end else begin
          cursor_next = cursor - CW'(1);
          gap_next    = gap + CW'(1);
        end
      end
      OP_DELETE: begin
        if (at_end) begin
          refused = 1'b1;
        end else begin
          gap_next = gap + CW'(1);
        end
      end
      OP_LEFT: begin
        if (cursor == '0) begin
          refused = 1'b1;
        end else begin
          mem_we      = exec_fire;
          waddr       = AW'(cursor + gap - CW'(1));
          wdata       = rdata;
          cursor_next = cursor - CW'(1);
        end
      end
      OP_RIGHT: begin
        if (at_end) begin
          refused = 1'b1;
        end else begin
          mem_we      = exec_fire;
          wdata       = rdata;
          cursor_next = cursor + CW'(1);
        end
      end
      OP_CLEAR: begin
        total_next  = cap_clamped;
        cursor_next = '0;
        gap_next    = cap_clamped;
      end
      OP_READ: begin
        if (XW'(idx_q) >= XW'(len)) begin
          refused = 1'b1;
        end else begin
          ch = rdata;
        end
      end
      default: refused = 1'b1;
    endcase
    len_next = total_next - gap_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_q   <= in_op;
      char_q <= in_char;
      idx_q  <= in_idx;
    end
    if (exec_fire) begin
      m_tdata <= {5'd0, refused, POS_W'(len_next), POS_W'(cursor_next), ch};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cap_reg  <= CFG_W'(CFG_RST);
      cursor   <= '0;
      gap      <= CW'(TOT_RST);
      total    <= CW'(TOT_RST);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
      if (exec_fire) begin
        cursor   <= cursor_next;
        gap      <= gap_next;
        total    <= total_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_we_in_exec: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_EXEC)
    else $error("memory write outside write-back cycle");

  a_re_in_idle: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> state == ST_IDLE)
    else $error("memory read outside accept cycle");

  a_gap_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cursor} + {1'b0, gap}) <= {1'b0, total})
    else $error("cursor plus gap beyond capacity");

  a_two_cycles: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("item accepted in consecutive cycles");

  a_out_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_EXEC)
    else $error("result raised without write-back");
`endif

endmodule

>>> dv/tb_top.sv
// self-checking testbench for gap_buffer_line_editor_top: edit items in, one line view out per item
// predicts cursor, length, status and read characters from its own gap buffer copy
// depends on gbed_pkg and the rtl of the block
module tb_top;
  import gbed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_CELLS = 256;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  len;
    logic              refused;
  } line_view_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                hold_req = 1'b0;
  int                  hold_left = 0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;

  logic [S_DATA_W-1:0] keystrokes[$];
  line_view_t          edit_results[$];

  // predicted editor state
  logic [CHAR_W-1:0] ed_store [BUF_CELLS];
  int ed_cursor = 0;
  int ed_gap = BUF_CELLS;
  int ed_total = BUF_CELLS;
  int ed_cap_reg = CFG_RST;

  // rough text shape seen by the stimulus generator
  int gen_cur = 0;
  int gen_len = 0;
  int gen_tot = BUF_CELLS;
  int gen_cap = CFG_RST;

  gap_buffer_line_editor_top #(
    .CAPACITY(BUF_CELLS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_cells(int v);
    if (v < 1) return 1;
    if (v > BUF_CELLS) return BUF_CELLS;
    return v;
  endfunction

  function automatic line_view_t edit_line(logic [S_DATA_W-1:0] word);
    line_view_t        r;
    logic [CHAR_W-1:0] ch;
    int                idx;
    bit                at_end;
    r = '0;
    ch = word[OP_W +: CHAR_W];
    idx = word[OP_W+CHAR_W +: IDX_W];
    at_end = (ed_cursor + ed_gap) >= ed_total;
    case (word[OP_W-1:0])
      OP_INSERT: begin
        if (ed_gap == 0) begin
          r.refused = 1'b1;
        end else begin
          ed_store[ed_cursor] = ch;
          ed_cursor++;
          ed_gap--;
        end
      end
      OP_BACKSPACE: begin
        if (ed_cursor == 0) begin
          r.refused = 1'b1;
        end else begin
          ed_cursor--;
          ed_gap++;
        end
      end
      OP_DELETE: begin
        if (at_end) r.refused = 1'b1;
        else ed_gap++;
      end
      OP_LEFT: begin
        if (ed_cursor == 0) begin
          r.refused = 1'b1;
        end else begin
          ed_store[ed_cursor + ed_gap - 1] = ed_store[ed_cursor - 1];
          ed_cursor--;
        end
      end
      OP_RIGHT: begin
        if (at_end) begin
          r.refused = 1'b1;
        end else begin
          ed_store[ed_cursor] = ed_store[ed_cursor + ed_gap];
          ed_cursor++;
        end
      end
      OP_CLEAR: begin
        ed_total = clamp_cells(ed_cap_reg);
        ed_cursor = 0;
        ed_gap = ed_total;
      end
      OP_READ: begin
        if (idx >= ed_total - ed_gap) r.refused = 1'b1;
        else r.ch = ed_store[idx < ed_cursor ? idx : idx + ed_gap];
      end
      default: r.refused = 1'b1;
    endcase
    r.cur = POS_W'(ed_cursor);
    r.len = POS_W'(ed_total - ed_gap);
    return r;
  endfunction

  // source side
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) edit_results.push_back(edit_line(s_tdata));
    if (!s_tvalid || s_tready) begin
      if (keystrokes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_tdata <= keystrokes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic report_field(string label, logic [POS_W-1:0] want_v, logic [POS_W-1:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
    end
  endtask

  // sink side
  always @(posedge clk) begin : sink
    line_view_t want;
    m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (edit_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
      end else begin
        want = edit_results.pop_front();
        report_field("char_out", POS_W'(want.ch), POS_W'(m_tdata[7:0]));
        report_field("cursor_pos", want.cur, m_tdata[16:8]);
        report_field("text_length", want.len, m_tdata[25:17]);
        report_field("status", POS_W'(want.refused), POS_W'(m_tdata[26]));
      end
    end
  end

  task automatic push_key(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    keystrokes.push_back(S_DATA_W'({idx, ch, op}));
    case (op)
      OP_INSERT: begin
        if (gen_len < gen_tot) begin
          gen_cur++;
          gen_len++;
        end
      end
      OP_BACKSPACE: begin
        if (gen_cur > 0) begin
          gen_cur--;
          gen_len--;
        end
      end
      OP_DELETE: if (gen_cur < gen_len) gen_len--;
      OP_LEFT: if (gen_cur > 0) gen_cur--;
      OP_RIGHT: if (gen_cur < gen_len) gen_cur++;
      OP_CLEAR: begin
        gen_tot = clamp_cells(gen_cap);
        gen_cur = 0;
        gen_len = 0;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    while (keystrokes.size() != 0 || s_tvalid || edit_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    ed_cap_reg = v;
    gen_cap = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int cap, int src_pct, int sink_pct, int n_keys, bit squeeze);
    int               made;
    int               r;
    int               burst;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    drain();
    set_capacity(cap);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    push_key(OP_CLEAR, 8'($urandom), 8'($urandom));
    made = 1;
    while (made < n_keys) begin
      r = $urandom_range(0, 99);
      burst = 1;
      if (r < 3) begin
        burst = gen_tot - gen_len + 1;
        op = OP_INSERT;
      end else if (r < 5) begin
        burst = gen_cur + 1;
        op = OP_LEFT;
      end else if (r < 7) begin
        burst = gen_len - gen_cur + 1;
        op = OP_RIGHT;
      end else if (r < 8) begin
        burst = gen_cur + 1;
        op = OP_BACKSPACE;
      end else if (r < 38) op = OP_INSERT;
      else if (r < 58) op = OP_READ;
      else if (r < 68) op = OP_LEFT;
      else if (r < 78) op = OP_RIGHT;
      else if (r < 86) op = OP_BACKSPACE;
      else if (r < 94) op = OP_DELETE;
      else if (r < 97) op = OP_CLEAR;
      else op = OP_UNUSED;
      repeat (burst) begin
        if (op == OP_READ && gen_len > 0 && $urandom_range(0, 7) != 0)
          idx = IDX_W'($urandom_range(0, gen_len - 1));
        else
          idx = IDX_W'($urandom);
        push_key(op, 8'($urandom), idx);
      end
      made += burst;
    end
    if (squeeze) begin
      @(posedge clk);
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty line at reset capacity
    push_key(OP_BACKSPACE, 8'h00, 8'h00);
    push_key(OP_DELETE, 8'hff, 8'hff);
    push_key(OP_LEFT, 8'h00, 8'h00);
    push_key(OP_RIGHT, 8'h00, 8'h00);
    push_key(OP_READ, 8'h00, 8'h00);
    push_key(OP_UNUSED, 8'hff, 8'hff);
    push_key(OP_INSERT, 8'h00, 8'h00);
    push_key(OP_INSERT, 8'hff, 8'h00);
    push_key(OP_INSERT, 8'h5a, 8'hff);
    push_key(OP_LEFT, 8'h00, 8'h00);
    push_key(OP_LEFT, 8'h00, 8'h00);
    push_key(OP_READ, 8'h00, 8'h00);
    push_key(OP_READ, 8'h00, 8'h02);
    push_key(OP_READ, 8'h00, 8'hff);
    push_key(OP_DELETE, 8'h00, 8'h00);
    push_key(OP_RIGHT, 8'h00, 8'h00);
    push_key(OP_BACKSPACE, 8'h00, 8'h00);
    push_key(OP_READ, 8'h00, 8'h00);
    drain();

    // zero capacity falls back to a single cell
    set_capacity(0);
    push_key(OP_CLEAR, 8'h00, 8'h00);
    push_key(OP_INSERT, 8'h41, 8'h00);
    push_key(OP_INSERT, 8'h42, 8'h00);
    push_key(OP_READ, 8'h00, 8'h00);
    push_key(OP_READ, 8'h00, 8'h01);
    push_key(OP_RIGHT, 8'h00, 8'h00);
    push_key(OP_LEFT, 8'h00, 8'h00);

    run_phase(511, 0, 0, 250, 1'b0);
    run_phase($urandom_range(2, 12), 67, 0, 250, 1'b0);
    run_phase(1, 0, 67, 150, 1'b0);
    run_phase($urandom_range(13, 40), 28, 28, 250, 1'b0);
    run_phase(256, 0, 0, 200, 1'b1);
    run_phase(2, 0, 0, 200, 1'b0);
    run_phase(300, 0, 67, 150, 1'b0);
    run_phase($urandom_range(3, 20), 28, 28, 200, 1'b0);
    run_phase($urandom_range(41, 255), 67, 0, 200, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
